### src/wave_sum_uv_warp_defines.svh
// ----------------------------------------------------------------------------
// wave_sum_uv_warp_defines
// assertion macros shared by the wave uv warp rtl
// ----------------------------------------------------------------------------
`ifndef WAVE_SUM_UV_WARP_DEFINES_SVH
`define WAVE_SUM_UV_WARP_DEFINES_SVH

// check on every clock edge outside reset
`define WSUV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wave_sum_uv_warp: check failed");

// check on the clock edge after one that sees reset asserted
`define WSUV_ASSERT_IN_RESET(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) !rst_n |=> prop) \
    else $error("wave_sum_uv_warp: reset check failed");

`endif

### src/wsuv_pkg.sv
// ----------------------------------------------------------------------------
// wsuv_pkg
// types, constants and tables of the wave uv warp block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsuv_pkg;

  localparam int unsigned AccW  = 40;
  localparam int unsigned GradW = 54;
  localparam int unsigned MulAW = 36;
  localparam int unsigned MulBW = 17;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned PiW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [PiW-1:0] PiQ29 = 32'sd1686629713;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_WAVES = 2'd0,
    CFG_SHIMMER_U    = 2'd1,
    CFG_SHIMMER_V    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    TAG_NONE,
    TAG_PH_SET,
    TAG_PH_ADD,
    TAG_PH_SUB,
    TAG_ACC_U,
    TAG_ACC_V,
    TAG_TMP,
    TAG_GX,
    TAG_GZ,
    TAG_SHM_U,
    TAG_SHM_V
  } mac_tag_e;

  typedef enum logic [1:0] {
    SRC_EXT,
    SRC_PROD,
    SRC_TMP,
    SRC_PI
  } a_src_e;

  typedef struct packed {
    mac_tag_e tag;
    a_src_e   src;
    logic     clear;
    logic     pi_load;
    logic     pi_z;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [15:0] kx;
    logic signed [15:0] kz;
    logic [15:0]        omega;
    logic [15:0]        amp_u;
    logic [15:0]        amp_v;
    logic [15:0]        phase_u;
    logic [15:0]        phase_v;
  } wave_t;

  // default wave set, entries past the fourth are zero
  function automatic wave_t wave_lookup(logic [3:0] idx);
    wave_t w;
    w = '0;
    case (idx)
      4'd0: w = '{kx: 16'sd7034, kz: 16'sd1885, omega: 16'd27296,
                  amp_u: 16'd20972, amp_v: 16'd18874, phase_u: 16'd0, phase_v: 16'd0};
      4'd1: w = '{kx: 16'sd2610, kz: 16'sd9739, omega: 16'd32119,
                  amp_u: 16'd14680, amp_v: 16'd16777, phase_u: 16'd11473,
                  phase_v: 16'd20861};
      4'd2: w = '{kx: -16'sd9268, kz: 16'sd9268, omega: 16'd36622,
                  amp_u: 16'd12583, amp_v: 16'd13631, phase_u: 16'd6258,
                  phase_v: 16'd17732};
      4'd3: w = '{kx: -16'sd6330, kz: -16'sd1696, omega: 16'd25896,
                  amp_u: 16'd10486, amp_v: 16'd10486, phase_u: 16'd22947,
                  phase_v: 16'd8344};
      default: w = '0;
    endcase
    return w;
  endfunction

  // q1.15 sine of a 32-bit turn fraction, quadrant fold and taylor series in q30
  function automatic logic [15:0] sine_q15(logic [63:0] p);
    logic [1:0]         q;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    q = p[31:30];
    r = {34'd0, p[29:0]};
    if (q[0]) begin
      r = (64'd1 << 30) - r;
    end
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    if (q[1]) begin
      sum = -sum;
    end
    return sum[15:0];
  endfunction

endpackage

`default_nettype wire

### src/wsuv_ram.sv
// ----------------------------------------------------------------------------
// wsuv_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsuv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/wsuv_sine_init.sv
// ----------------------------------------------------------------------------
// wsuv_sine_init
// fills the sine ram after reset, one entry per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsuv_sine_init #(
  parameter int unsigned SINE_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  output logic                            we_o,
  output logic [$clog2(SINE_ENTRIES)-1:0] addr_o,
  output logic [15:0]                     data_o,
  output logic                            done_o
);

  import wsuv_pkg::*;

  localparam int unsigned IdxW = $clog2(SINE_ENTRIES);
  localparam int unsigned CntW = $clog2(SINE_ENTRIES + 1);

  logic [CntW-1:0] cnt_q;
  logic [15:0]     rom_w [SINE_ENTRIES];

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
    localparam logic [63:0] Turn = (64'(g) << 32) / SINE_ENTRIES;
    assign rom_w[g] = sine_q15(Turn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (!done_o) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  assign done_o = (cnt_q == CntW'(SINE_ENTRIES));
  assign we_o   = !done_o;
  assign addr_o = cnt_q[IdxW-1:0];
  assign data_o = rom_w[cnt_q[IdxW-1:0]];

endmodule

`default_nettype wire

### src/wsuv_mac.sv
// ----------------------------------------------------------------------------
// wsuv_mac
// shared multiplier with phase, sum and gradient accumulators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsuv_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  wsuv_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [wsuv_pkg::MulAW-1:0]       a_i,
  input  logic signed [wsuv_pkg::MulBW-1:0]       b_i,
  output logic [31:0]                             phase_o,
  output logic signed [wsuv_pkg::AccW-1:0]        acc_u_o,
  output logic signed [wsuv_pkg::AccW-1:0]        acc_v_o
);

  import wsuv_pkg::*;

  localparam int unsigned GSelW = GradW - 20;
  localparam int unsigned PiProdW = GSelW + PiW;

  logic signed [MulAW-1:0]   a_w;
  logic signed [ProdW-1:0]   prod_q;
  mac_tag_e                  tag_q;
  logic signed [MulAW-1:0]   tmp_q;
  logic [31:0]               ph_q;
  logic signed [AccW-1:0]    acc_u_q;
  logic signed [AccW-1:0]    acc_v_q;
  logic signed [GradW-1:0]   gx_q;
  logic signed [GradW-1:0]   gz_q;
  logic signed [GradW-1:0]   g_full_w;
  logic signed [GSelW-1:0]   g_sel_w;
  logic signed [PiProdW-1:0] pi_prod_w;
  logic signed [MulAW-1:0]   pim_q;

  always_comb begin
    case (ctrl_i.src)
      SRC_EXT:  a_w = a_i;
      SRC_PROD: a_w = prod_q[MulAW-1:0];
      SRC_TMP:  a_w = tmp_q;
      SRC_PI:   a_w = pim_q;
      default:  a_w = a_i;
    endcase
  end

  // floored gradient sum scaled by pi
  assign g_full_w  = ctrl_i.pi_z ? gz_q : gx_q;
  assign g_sel_w   = g_full_w[GradW-1:20];
  assign pi_prod_w = g_sel_w * PiQ29;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= TAG_NONE;
    end else begin
      tag_q <= ctrl_i.tag;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_w * b_i;
    if (ctrl_i.pi_load) begin
      pim_q <= pi_prod_w[29 +: MulAW];
    end
    if (ctrl_i.clear) begin
      acc_u_q <= '0;
      acc_v_q <= '0;
      gx_q    <= '0;
      gz_q    <= '0;
    end else begin
      case (tag_q)
        TAG_PH_SET: ph_q    <= prod_q[31:0];
        TAG_PH_ADD: ph_q    <= ph_q + prod_q[31:0];
        TAG_PH_SUB: ph_q    <= ph_q - prod_q[31:0];
        TAG_ACC_U:  acc_u_q <= acc_u_q + AccW'(prod_q);
        TAG_ACC_V:  acc_v_q <= acc_v_q + AccW'(prod_q);
        TAG_TMP:    tmp_q   <= prod_q[MulAW-1:0];
        TAG_GX:     gx_q    <= gx_q + GradW'(prod_q);
        TAG_GZ:     gz_q    <= gz_q + GradW'(prod_q);
        TAG_SHM_U:  acc_u_q <= acc_u_q + AccW'(prod_q >>> 16);
        TAG_SHM_V:  acc_v_q <= acc_v_q + AccW'(prod_q >>> 16);
        default: ;
      endcase
    end
  end

  assign phase_o = ph_q;
  assign acc_u_o = acc_u_q;
  assign acc_v_o = acc_v_q;

endmodule

`default_nettype wire

### src/wave_sum_uv_warp.sv
// ----------------------------------------------------------------------------
// wave_sum_uv_warp
// sum of sines uv displacement for one world position and time per beat
// ----------------------------------------------------------------------------
// flow: a new beat is taken only once the result of the beat before is in the output register;
//   the summed waves are worked one after another through the single shared multiplier
//   and the one read port of the sine ram
// reset: the sine ram is filled first and no input beat is taken
//   meanwhile; configuration writes are taken at any time
`timescale 1ns / 1ps
`default_nettype none
`include "wave_sum_uv_warp_defines.svh"

module wave_sum_uv_warp #(
  parameter int unsigned MAX_WAVES    = 4,
  parameter int unsigned SINE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // x_pos, z_pos, time_now
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // offset_u, offset_v
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  import wsuv_pkg::*;

  localparam int unsigned IdxW  = $clog2(SINE_ENTRIES);
  localparam int unsigned WIdxW = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
  localparam int unsigned WCntW = $clog2(MAX_WAVES + 1);

  typedef enum logic [4:0] {
    ST_FILL,
    ST_IDLE,
    ST_KX,
    ST_KZ,
    ST_OM,
    ST_PH,
    ST_RD_U,
    ST_MU,
    ST_MV,
    ST_MA,
    ST_GX,
    ST_GZ,
    ST_FIN0,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [WIdxW-1:0]       widx_q;
  logic [WCntW-1:0]       cnt_q;
  logic [WCntW-1:0]       cnt_w;
  logic signed [31:0]     x_q;
  logic signed [31:0]     z_q;
  logic [31:0]            t_q;
  logic [2:0]             active_q;
  logic signed [15:0]     scale_u_q;
  logic signed [15:0]     scale_v_q;
  logic                   m_valid_q;
  logic [31:0]            out_u_q;
  logic [31:0]            out_v_q;

  logic                   s_accept_w;
  logic                   last_w;
  logic                   out_load_w;
  wave_t                  wave_w;
  logic [16:0]            asum_w;

  logic                   fill_we_w;
  logic [IdxW-1:0]        fill_addr_w;
  logic [15:0]            fill_data_w;
  logic                   fill_done_w;
  logic [IdxW-1:0]        rd_addr_w;
  logic [15:0]            rd_data_w;
  logic signed [15:0]     sin_w;

  mac_ctrl_t              mac_ctrl_w;
  logic signed [MulAW-1:0] mac_a_w;
  logic signed [MulBW-1:0] mac_b_w;
  logic [31:0]            ph_w;
  logic signed [AccW-1:0] acc_u_w;
  logic signed [AccW-1:0] acc_v_w;

  function automatic logic [IdxW-1:0] sine_idx(logic [31:0] frac);
    logic [63:0] prod;
    prod = {32'd0, frac} * 64'(SINE_ENTRIES);
    return prod[32 +: IdxW];
  endfunction

  function automatic logic [31:0] sat_q29(logic signed [AccW-1:0] acc);
    logic [AccW-7:0] v;
    v = acc[AccW-1:6];
    if (!((&v[AccW-7:31]) || !(|v[AccW-7:31]))) begin
      return v[AccW-7] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

  wsuv_sine_init #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_sine_init (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_o   (fill_we_w),
    .addr_o (fill_addr_w),
    .data_o (fill_data_w),
    .done_o (fill_done_w)
  );

  wsuv_ram #(
    .WIDTH(16),
    .DEPTH(SINE_ENTRIES)
  ) u_sine_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we_w),
    .waddr_i (fill_addr_w),
    .wdata_i (fill_data_w),
    .raddr_i (rd_addr_w),
    .rdata_o (rd_data_w)
  );

  wsuv_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl_w),
    .a_i     (mac_a_w),
    .b_i     (mac_b_w),
    .phase_o (ph_w),
    .acc_u_o (acc_u_w),
    .acc_v_o (acc_v_w)
  );

  assign sin_w      = rd_data_w;
  assign wave_w     = wave_lookup(4'(widx_q));
  assign asum_w     = {1'b0, wave_w.amp_u} + {1'b0, wave_w.amp_v};
  assign s_accept_w = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_w      = (active_q > MAX_WAVES) ? WCntW'(MAX_WAVES) : WCntW'(active_q);
  assign last_w     = (WCntW'(widx_q) + WCntW'(1)) == cnt_q;
  assign out_load_w = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i);

  // at most one multiply issued per cycle, accumulated from the registered product and tag
  always_comb begin
    mac_ctrl_w = '0;
    mac_a_w    = '0;
    mac_b_w    = '0;
    rd_addr_w  = '0;
    case (state_q)
      ST_IDLE: begin
        mac_ctrl_w.clear = s_accept_w;
      end
      ST_KX: begin
        mac_a_w = MulAW'(x_q);
        mac_b_w = MulBW'(wave_w.kx);
        mac_ctrl_w.tag = TAG_PH_SET;
      end
      ST_KZ: begin
        mac_a_w = MulAW'(z_q);
        mac_b_w = MulBW'(wave_w.kz);
        mac_ctrl_w.tag = TAG_PH_ADD;
      end
      ST_OM: begin
        mac_a_w = MulAW'(t_q);
        mac_b_w = MulBW'(wave_w.omega);
        mac_ctrl_w.tag = TAG_PH_SUB;
      end
      ST_RD_U: begin
        rd_addr_w = sine_idx(ph_w + {wave_w.phase_u, 16'h0000});
      end
      ST_MU: begin
        mac_a_w = MulAW'(sin_w);
        mac_b_w = MulBW'(wave_w.amp_u);
        mac_ctrl_w.tag = TAG_ACC_U;
        rd_addr_w = sine_idx(ph_w + {wave_w.phase_v, 16'h0000} + QuarterTurn);
      end
      ST_MV: begin
        mac_a_w = MulAW'(sin_w);
        mac_b_w = MulBW'(wave_w.amp_v);
        mac_ctrl_w.tag = TAG_ACC_V;
        rd_addr_w = sine_idx(ph_w + QuarterTurn);
      end
      ST_MA: begin
        mac_a_w = MulAW'(asum_w);
        mac_b_w = MulBW'(sin_w);
        mac_ctrl_w.tag = TAG_TMP;
      end
      ST_GX: begin
        mac_ctrl_w.src = SRC_PROD;
        mac_b_w = MulBW'(wave_w.kx);
        mac_ctrl_w.tag = TAG_GX;
      end
      ST_GZ: begin
        mac_ctrl_w.src = SRC_TMP;
        mac_b_w = MulBW'(wave_w.kz);
        mac_ctrl_w.tag = TAG_GZ;
      end
      ST_FIN0: begin
        mac_ctrl_w.pi_load = 1'b1;
      end
      ST_FIN1: begin
        mac_ctrl_w.pi_load = 1'b1;
        mac_ctrl_w.pi_z = 1'b1;
        mac_ctrl_w.src = SRC_PI;
        mac_b_w = MulBW'(scale_u_q);
        mac_ctrl_w.tag = TAG_SHM_U;
      end
      ST_FIN2: begin
        mac_ctrl_w.src = SRC_PI;
        mac_b_w = MulBW'(scale_v_q);
        mac_ctrl_w.tag = TAG_SHM_V;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_FILL;
      widx_q    <= '0;
      cnt_q     <= '0;
      x_q       <= '0;
      z_q       <= '0;
      t_q       <= '0;
      m_valid_q <= 1'b0;
      out_u_q   <= '0;
      out_v_q   <= '0;
    end else begin
      if (out_load_w) begin
        m_valid_q <= 1'b1;
        out_u_q   <= sat_q29(acc_u_w);
        out_v_q   <= sat_q29(acc_v_w);
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_FILL: begin
          if (fill_done_w) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_accept_w) begin
            x_q    <= s_axis_tdata_i[31:0];
            z_q    <= s_axis_tdata_i[63:32];
            t_q    <= s_axis_tdata_i[95:64];
            widx_q <= '0;
            cnt_q  <= cnt_w;
            state_q <= (cnt_w == '0) ? ST_FIN0 : ST_KX;
          end
        end
        ST_KX:   state_q <= ST_KZ;
        ST_KZ:   state_q <= ST_OM;
        ST_OM:   state_q <= ST_PH;
        ST_PH:   state_q <= ST_RD_U;
        ST_RD_U: state_q <= ST_MU;
        ST_MU:   state_q <= ST_MV;
        ST_MV:   state_q <= ST_MA;
        ST_MA:   state_q <= ST_GX;
        ST_GX:   state_q <= ST_GZ;
        ST_GZ: begin
          if (last_w) begin
            state_q <= ST_FIN0;
          end else begin
            widx_q  <= widx_q + WIdxW'(1);
            state_q <= ST_KX;
          end
        end
        ST_FIN0: state_q <= ST_FIN1;
        ST_FIN1: state_q <= ST_FIN2;
        ST_FIN2: state_q <= ST_FIN3;
        ST_FIN3: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_load_w) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 3'd4;
      scale_u_q <= 16'sd4194;
      scale_v_q <= 16'sd4194;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ACTIVE_WAVES: active_q  <= cfg_data_i[2:0];
        CFG_SHIMMER_U:    scale_u_q <= cfg_data_i;
        CFG_SHIMMER_V:    scale_v_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_v_q, out_u_q};
  assign cfg_ready_o     = 1'b1;

  `WSUV_ASSERT(a_ready_after_fill, clk_i, rst_ni, s_axis_tready_o |-> fill_done_w)
  `WSUV_ASSERT(a_empty_skips_loop, clk_i, rst_ni, (s_accept_w && (active_q == 3'd0)) |=> (state_q == ST_FIN0))
  `WSUV_ASSERT(a_wave_idx_range, clk_i, rst_ni, (state_q == ST_KX) |-> (WCntW'(widx_q) < cnt_q))
  `WSUV_ASSERT(a_load_sets_valid, clk_i, rst_ni, out_load_w |=> m_axis_tvalid_o)
  `WSUV_ASSERT_IN_RESET(a_reset_quiet, clk_i, rst_ni, !s_axis_tready_o && !m_axis_tvalid_o)

endmodule

`default_nettype wire

### bench/wave_sum_uv_warp_tb.sv
// ----------------------------------------------------------------------------
// wave_sum_uv_warp_tb
// self-checking bench for the sum of sines uv warp block. a directed table
// covers coordinate and time extremes, every wave count including zero and
// too many, and the shimmer gains at both ends; random points follow under
// changing register settings and random idling on both streams. every output
// beat is checked against a fixed-point model of the wave sum kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wave_sum_uv_warp_tb;
  import wsuv_pkg::*;

  localparam int unsigned MAX_WAVES    = 4;
  localparam int unsigned SINE_ENTRIES = 256;
  localparam int unsigned SINE_BITS    = $clog2(SINE_ENTRIES);
  localparam int          CLK_PERIOD   = 10;
  localparam int          ROWS         = 19;
  localparam int          PHASES       = 12;
  localparam int          PHASE_ITEMS  = 115;
  localparam int          LONG_HOLD    = 300;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          STALL_LIMIT  = 4000;

  localparam longint            PI_Q29   = 64'sd1686629713;
  localparam logic [31:0]       QUARTER  = 32'h4000_0000;
  localparam logic signed [31:0] MAX_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_POS = 32'sh8000_0000;
  localparam logic signed [15:0] DEF_GAIN = 16'sd4194;
  localparam logic signed [15:0] MAX_GAIN = 16'sh7FFF;
  localparam logic signed [15:0] MIN_GAIN = 16'sh8000;

  typedef struct packed {
    logic [31:0]        time_now;
    logic signed [31:0] z_pos;
    logic signed [31:0] x_pos;
  } point_t;

  typedef struct packed {
    logic signed [31:0] offset_v;
    logic signed [31:0] offset_u;
  } offset_t;

  typedef struct {
    logic [2:0]         waves;
    logic signed [15:0] gain_u;
    logic signed [15:0] gain_v;
    point_t             pt;
    bit                 fixed;
    offset_t            want;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;   // x_pos, z_pos, time_now
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // offset_u, offset_v
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  wave_t              wave_bank [MAX_WAVES];
  logic signed [15:0] sine_rom [SINE_ENTRIES];
  logic [2:0]         live_waves;
  logic signed [15:0] gain_u;
  logic signed [15:0] gain_v;

  offset_t offset_fifo [$];
  probe_t  probe_rows [ROWS];
  bit      src_pauses_on;
  bit      sink_pauses_on;
  int      points_sent;
  int      offsets_seen;
  int      mismatches;
  int      settings_applied;
  int      stall_cycles;

  wave_sum_uv_warp #(
    .MAX_WAVES   (MAX_WAVES),
    .SINE_ENTRIES(SINE_ENTRIES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [31:0] lane_product(longint a, longint b);
    return 32'(a * b);
  endfunction

  function automatic offset_t warp_offsets(point_t p);
    longint      acc_u;
    longint      acc_v;
    longint      grad_x;
    longint      grad_z;
    longint      px;
    longint      pz;
    longint      amp_sum;
    longint      cosv;
    logic [31:0] ph;
    logic [31:0] pu;
    logic [31:0] pv;
    logic [31:0] pc;
    int          n;
    wave_t       w;
    offset_t     r;
    n = (live_waves > MAX_WAVES) ? MAX_WAVES : int'(live_waves);
    acc_u = 0;
    acc_v = 0;
    grad_x = 0;
    grad_z = 0;
    for (int i = 0; i < n; i++) begin
      w = wave_bank[i];
      ph = lane_product(longint'($signed(w.kx)), longint'($signed(p.x_pos)))
         + lane_product(longint'($signed(w.kz)), longint'($signed(p.z_pos)))
         - lane_product(longint'(w.omega), longint'(p.time_now));
      pc = ph + QUARTER;
      pu = ph + {w.phase_u, 16'd0};
      pv = ph + {w.phase_v, 16'd0} + QUARTER;
      cosv = sine_rom[pc[31 -: SINE_BITS]];
      amp_sum = longint'(w.amp_u) + longint'(w.amp_v);
      acc_u += longint'(w.amp_u) * longint'(sine_rom[pu[31 -: SINE_BITS]]);
      acc_v += longint'(w.amp_v) * longint'(sine_rom[pv[31 -: SINE_BITS]]);
      grad_x += amp_sum * longint'($signed(w.kx)) * cosv;
      grad_z += amp_sum * longint'($signed(w.kz)) * cosv;
    end
    px = ((grad_x >>> 20) * PI_Q29) >>> 29;
    pz = ((grad_z >>> 20) * PI_Q29) >>> 29;
    acc_u += (px * longint'(gain_u)) >>> 16;
    acc_v += (pz * longint'(gain_v)) >>> 16;
    acc_u = acc_u >>> 6;
    acc_v = acc_v >>> 6;
    if (acc_u > 64'sd2147483647) acc_u = 64'sd2147483647;
    if (acc_u < -64'sd2147483648) acc_u = -64'sd2147483648;
    if (acc_v > 64'sd2147483647) acc_v = 64'sd2147483647;
    if (acc_v < -64'sd2147483648) acc_v = -64'sd2147483648;
    r.offset_u = acc_u[31:0];
    r.offset_v = acc_v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'sd0;
      1: return MAX_GAIN;
      2: return MIN_GAIN;
      3: return DEF_GAIN;
      default: return 16'($urandom);
    endcase
  endfunction

  // registers change only with the stream stopped and nothing in flight
  task automatic apply_setting(input logic [2:0] waves, input logic signed [15:0] gu,
                               input logic signed [15:0] gv);
    cfg_idx_e regs [3];
    regs = '{CFG_ACTIVE_WAVES, CFG_SHIMMER_U, CFG_SHIMMER_V};
    s_axis_tvalid_i <= 1'b0;
    wait (offset_fifo.size() == 0);
    cfg_valid_i <= 1'b1;
    foreach (regs[k]) begin
      cfg_index_i <= regs[k];
      case (regs[k])
        CFG_ACTIVE_WAVES: cfg_data_i <= {13'd0, waves};
        CFG_SHIMMER_U:    cfg_data_i <= gu;
        default:          cfg_data_i <= gv;
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    live_waves = waves;
    gain_u = gu;
    gain_v = gv;
    settings_applied++;
  endtask

  // valid stays high into the next beat unless a gap is drawn
  task automatic send_point(input point_t p, input bit fixed, input offset_t want);
    int gap;
    gap = src_pauses_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= p;
    do @(posedge clk_i); while (!s_axis_tready_o);
    offset_fifo.push_back(fixed ? want : warp_offsets(p));
    points_sent++;
  endtask

  initial begin
    int gap;
    offset_t got;
    offset_t want;
    wait (rst_ni);
    forever begin
      gap = sink_pauses_on ? $urandom_range(0, 12) : 0;
      if (offsets_seen == 150 || offsets_seen == 760) gap = LONG_HOLD;
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got = m_axis_tdata_o;
      offsets_seen++;
      if (offset_fifo.size() == 0) begin
        $error("unexpected offset beat: offset_u %0d offset_v %0d",
               got.offset_u, got.offset_v);
        mismatches++;
      end else begin
        want = offset_fifo.pop_front();
        if (got.offset_u !== want.offset_u) begin
          $error("offset_u mismatch: expected %0d, actual %0d", want.offset_u, got.offset_u);
          mismatches++;
        end
        if (got.offset_v !== want.offset_v) begin
          $error("offset_v mismatch: expected %0d, actual %0d", want.offset_v, got.offset_v);
          mismatches++;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: no beat for %0d cycles, %0d offsets pending",
             STALL_LIMIT, offset_fifo.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [63:0] turn;
    logic [63:0] rem;
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    logic [1:0]  quad;
    longint      acc;
    probe_t      row;
    point_t      p;
    logic [2:0]  waves;

    // q1.15 sine rom: quadrant fold, then taylor series to the 13th power in q30
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      turn = (64'(i) << 32) / SINE_ENTRIES;
      quad = turn[31:30];
      rem = {34'd0, turn[29:0]};
      if (quad[0]) rem = (64'd1 << 30) - rem;
      ang = (rem * 64'(PI_Q29)) >> 30;
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc = $signed(ang);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 64'sd16384) >>> 15;
      if (acc > 64'sd32767) acc = 64'sd32767;
      if (quad[1]) acc = -acc;
      sine_rom[i] = acc[15:0];
    end

    wave_bank[0] = '{kx: 16'sd7034, kz: 16'sd1885, omega: 16'd27296, amp_u: 16'd20972,
                     amp_v: 16'd18874, phase_u: 16'd0, phase_v: 16'd0};
    wave_bank[1] = '{kx: 16'sd2610, kz: 16'sd9739, omega: 16'd32119, amp_u: 16'd14680,
                     amp_v: 16'd16777, phase_u: 16'd11473, phase_v: 16'd20861};
    wave_bank[2] = '{kx: -16'sd9268, kz: 16'sd9268, omega: 16'd36622, amp_u: 16'd12583,
                     amp_v: 16'd13631, phase_u: 16'd6258, phase_v: 16'd17732};
    wave_bank[3] = '{kx: -16'sd6330, kz: -16'sd1696, omega: 16'd25896, amp_u: 16'd10486,
                     amp_v: 16'd10486, phase_u: 16'd22947, phase_v: 16'd8344};
    live_waves = 3'd4;
    gain_u = DEF_GAIN;
    gain_v = DEF_GAIN;

    probe_rows = '{
      // reset settings, coordinate and time extremes
      '{3'd4, DEF_GAIN, DEF_GAIN, '{x_pos: 32'sd0, z_pos: 32'sd0, time_now: 32'd0},
        1'b0, '0},
      '{3'd4, DEF_GAIN, DEF_GAIN, '{x_pos: MAX_POS, z_pos: MAX_POS, time_now: 32'hFFFF_FFFF},
        1'b0, '0},
      '{3'd4, DEF_GAIN, DEF_GAIN, '{x_pos: MIN_POS, z_pos: MIN_POS, time_now: 32'd0},
        1'b0, '0},
      '{3'd4, DEF_GAIN, DEF_GAIN, '{x_pos: MIN_POS, z_pos: MAX_POS, time_now: 32'hFFFF_FFFF},
        1'b0, '0},
      '{3'd4, DEF_GAIN, DEF_GAIN, '{x_pos: -32'sd1, z_pos: -32'sd1, time_now: 32'd1},
        1'b0, '0},
      '{3'd4, DEF_GAIN, DEF_GAIN,
        '{x_pos: 32'sh0001_0000, z_pos: 32'sh0002_8000, time_now: 32'h0003_0000}, 1'b0, '0},
      // no waves gives zero offsets
      '{3'd0, DEF_GAIN, DEF_GAIN, '{x_pos: MAX_POS, z_pos: MIN_POS, time_now: 32'hFFFF_FFFF},
        1'b1, '{offset_v: 32'sd0, offset_u: 32'sd0}},
      '{3'd0, MAX_GAIN, MIN_GAIN,
        '{x_pos: 32'sd12345678, z_pos: -32'sd7654321, time_now: 32'd99},
        1'b1, '{offset_v: 32'sd0, offset_u: 32'sd0}},
      // wave counts above the table size, then one to three waves
      '{3'd7, DEF_GAIN, DEF_GAIN,
        '{x_pos: 32'sh0001_8000, z_pos: -32'sh0004_0000, time_now: 32'h0010_0000}, 1'b0, '0},
      '{3'd5, DEF_GAIN, DEF_GAIN,
        '{x_pos: 32'sh0001_8000, z_pos: -32'sh0004_0000, time_now: 32'h0010_0000}, 1'b0, '0},
      '{3'd1, DEF_GAIN, DEF_GAIN,
        '{x_pos: 32'sh0002_0000, z_pos: 32'sd0, time_now: 32'h0000_4000}, 1'b0, '0},
      '{3'd2, DEF_GAIN, DEF_GAIN,
        '{x_pos: -32'sh0003_4000, z_pos: 32'sh0000_c000, time_now: 32'h0001_0000}, 1'b0, '0},
      '{3'd3, DEF_GAIN, DEF_GAIN,
        '{x_pos: 32'sh0007_0000, z_pos: -32'sh0001_0000, time_now: 32'h0005_8000}, 1'b0, '0},
      // shimmer off, gains at both extremes, then the default gains
      '{3'd4, 16'sd0, 16'sd0,
        '{x_pos: 32'sh0003_0000, z_pos: 32'sh0001_0000, time_now: 32'h0002_0000}, 1'b0, '0},
      '{3'd4, MAX_GAIN, MIN_GAIN,
        '{x_pos: -32'sh0002_0000, z_pos: 32'sh0005_0000, time_now: 32'h0000_8000}, 1'b0, '0},
      '{3'd4, MIN_GAIN, MAX_GAIN,
        '{x_pos: 32'sh0000_4000, z_pos: -32'sh0006_0000, time_now: 32'h0009_0000}, 1'b0, '0},
      '{3'd4, MAX_GAIN, MAX_GAIN, '{x_pos: MAX_POS, z_pos: MIN_POS, time_now: 32'h8000_0000},
        1'b0, '0},
      '{3'd4, MIN_GAIN, MIN_GAIN,
        '{x_pos: 32'sh5555_5555, z_pos: 32'shAAAA_AAAA, time_now: 32'hAAAA_AAAA}, 1'b0, '0},
      '{3'd4, DEF_GAIN, DEF_GAIN,
        '{x_pos: 32'shAAAA_AAAA, z_pos: 32'sh5555_5555, time_now: 32'h5555_5555}, 1'b0, '0}
    };

    src_pauses_on = 1'b1;
    sink_pauses_on = 1'b1;
    points_sent = 0;
    offsets_seen = 0;
    mismatches = 0;
    settings_applied = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (probe_rows[r]) begin
      row = probe_rows[r];
      if (row.waves != live_waves || row.gain_u != gain_u || row.gain_v != gain_v) begin
        apply_setting(row.waves, row.gain_u, row.gain_v);
      end
      send_point(row.pt, row.fixed, row.want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      waves = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      apply_setting(waves, pick_gain(), pick_gain());
      src_pauses_on = ($urandom_range(0, 3) != 0);
      sink_pauses_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        p = {$urandom, $urandom, $urandom};
        // mostly metres near the origin and short times, where the waves resolve
        if ($urandom_range(0, 3) != 0) begin
          p.x_pos = {{11{p.x_pos[20]}}, p.x_pos[20:0]};
          p.z_pos = {{11{p.z_pos[20]}}, p.z_pos[20:0]};
          p.time_now = {12'd0, p.time_now[19:0]};
        end
        send_point(p, 1'b0, '0);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    wait (offset_fifo.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d points under %0d register settings: wave counts from none",
             points_sent, settings_applied);
    $display("to past the table, shimmer gains at both limits and off, %0d offset beats, %0d mismatches",
             offsets_seen, mismatches);
    if (mismatches == 0 && offset_fifo.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/wsuv_pkg.sv
src/wsuv_ram.sv
src/wsuv_sine_init.sv
src/wsuv_mac.sv
src/wave_sum_uv_warp.sv
bench/wave_sum_uv_warp_tb.sv
